// ===== rtl/b64d_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character codes and the alphabet lookup of the Base64 stream decoder.
package b64d_pkg;

	// Character codes that bound the standard alphabet
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;

	// Sextet offsets of each alphabet range
	localparam logic [5:0] SEXTET_LOWER = 6'd26;
	localparam logic [5:0] SEXTET_DIGIT = 6'd52;
	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;

	// Pending bit counts between characters
	localparam logic [2:0] PEND_0 = 3'd0;
	localparam logic [2:0] PEND_2 = 3'd2;
	localparam logic [2:0] PEND_4 = 3'd4;
	localparam logic [2:0] PEND_6 = 3'd6;

	// One classified character as it travels from the front to the back
	typedef struct packed {
		logic [5:0] sextet;
		logic       bad;
		logic       last;
	} cls_t;

	function automatic cls_t classify(input logic [7:0] c, input logic last);
		cls_t r;
		r.sextet = '0;
		r.bad    = 1'b0;
		r.last   = last;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r.sextet = 6'(c - CHAR_UPPER_A);
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			r.sextet = 6'(c - CHAR_LOWER_A) + SEXTET_LOWER;
		end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
			r.sextet = 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT;
		end else if (c == CHAR_PLUS) begin
			r.sextet = SEXTET_PLUS;
		end else if (c == CHAR_SLASH) begin
			r.sextet = SEXTET_SLASH;
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/b64d_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts characters and classifies them into sextets for the queue.
module b64d_front (
	input  logic [7:0]      text_char,
	input  logic            end_of_text,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            q_full,
	output logic            q_push,
	output b64d_pkg::cls_t  q_item
);
	import b64d_pkg::*;

	// Stall only while the queue has no room
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;
	assign q_item   = classify(text_char, end_of_text);

endmodule

// ===== rtl/b64d_fifo.sv =====
`timescale 1ns / 1ps
// Short queue of classified characters between the front and back ends.
module b64d_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b64d_pkg::cls_t  push_item,
	output logic            full,
	input  logic            pop,
	output b64d_pkg::cls_t  pop_item,
	output logic            empty
);
	import b64d_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

	cls_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == DEPTH_CNT);
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/b64d_back.sv =====
`timescale 1ns / 1ps
// Back end: packs sextets into bytes and holds each result in an output register.
module b64d_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  b64d_pkg::cls_t  q_item,
	output logic            q_pop,
	output logic [7:0]      data_byte,
	output logic            byte_valid,
	output logic            text_done,
	output logic            out_valid,
	input  logic            out_stall
);
	import b64d_pkg::*;

	logic [5:0] acc_q;
	logic [2:0] pend_q;
	logic       halted_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       got_q;
	logic       done_q;

	logic [5:0] acc_n;
	logic [2:0] pend_n;
	logic       halt_n;
	logic       got;
	logic [7:0] dec_byte;
	logic       emit;

	// Take the next character when the output register is free or being drained
	assign q_pop = !q_empty && (!valid_q || !out_stall);
	assign emit  = q_pop && (got || q_item.last);

	always_comb begin
		acc_n    = acc_q;
		pend_n   = pend_q;
		halt_n   = halted_q;
		got      = 1'b0;
		dec_byte = '0;
		if (!halted_q) begin
			if (q_item.bad) begin
				// drop pending bits and ignore the rest of the text
				halt_n = 1'b1;
				acc_n  = '0;
				pend_n = PEND_0;
			end else begin
				unique case (pend_q)
					PEND_2: begin
						got      = 1'b1;
						dec_byte = {acc_q[1:0], q_item.sextet};
						acc_n    = '0;
						pend_n   = PEND_0;
					end
					PEND_4: begin
						got      = 1'b1;
						dec_byte = {acc_q[3:0], q_item.sextet[5:2]};
						acc_n    = {4'b0, q_item.sextet[1:0]};
						pend_n   = PEND_2;
					end
					PEND_6: begin
						got      = 1'b1;
						dec_byte = {acc_q[5:0], q_item.sextet[5:4]};
						acc_n    = {2'b0, q_item.sextet[3:0]};
						pend_n   = PEND_4;
					end
					default: begin
						acc_n  = q_item.sextet;
						pend_n = PEND_6;
					end
				endcase
			end
		end
		if (q_item.last) begin
			// leftover bits are dropped and decoding starts afresh
			acc_n  = '0;
			pend_n = PEND_0;
			halt_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			pend_q   <= PEND_0;
			halted_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				acc_q    <= acc_n;
				pend_q   <= pend_n;
				halted_q <= halt_n;
				valid_q  <= emit;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= dec_byte;
			got_q  <= got;
			done_q <= q_item.last;
		end
	end

	assign out_valid  = valid_q;
	assign data_byte  = byte_q;
	assign byte_valid = got_q;
	assign text_done  = done_q;

endmodule

// ===== rtl/base64_stream_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the Base64 stream decoder: front end, character queue and back end.
//
// Input channel: one ASCII character per transfer on text_char, with end_of_text
// marking the last character of the encoded text. A transfer happens on a rising
// edge where in_valid is high and in_stall is low.
// Output channel: data_byte, byte_valid and text_done, transferred on a rising
// edge where out_valid is high and out_stall is low. A character that completes a
// byte gives one result; the last character always gives one result with
// text_done set, and byte_valid then says whether it completed a byte.
// The first character outside the standard alphabet ('=' padding included) drops
// the pending bits and halts decoding until the end of the text.
// A character written into the queue is popped by the back end, which registers
// its result in the output register and raises out_valid. Throughput: one
// character per cycle while neither channel stalls, set by the combinational
// sextet lookup in the front end and the single pack step in the back end.
// When the receiver stalls, the output register holds its result, the queue
// fills, and in_stall rises once QUEUE_DEPTH characters are waiting.
// Reset (arst_n low) empties the queue, clears the accumulator, the pending count
// and the halt flag, and drops any result not yet transferred.
module base64_stream_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] text_char,
	input  logic       end_of_text,
	input  logic       in_valid,
	output logic       in_stall,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       text_done,
	output logic       out_valid,
	input  logic       out_stall
);
	import b64d_pkg::*;

	cls_t push_item;
	cls_t pop_item;
	logic push;
	logic pop;
	logic full;
	logic empty;

	// Classify each character on its way into the queue
	b64d_front u_front (
		.text_char   (text_char),
		.end_of_text (end_of_text),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.q_full      (full),
		.q_push      (push),
		.q_item      (push_item)
	);

	// Decouple the two ends so each can stall on its own
	b64d_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	// Pack sextets into bytes and hold results for the receiver
	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (empty),
		.q_item     (pop_item),
		.q_pop      (pop),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.text_done  (text_done),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

endmodule
